>>> hw/rtl/rapf_pkg.sv
// ----------------------------------------------------------------------------
// rapf_pkg
// Types and constants shared by the RED audio packet framer modules.
// ----------------------------------------------------------------------------
package rapf_pkg;

    // Input selector codes
    localparam logic [1:0] FUNC_DESC = 2'd0;
    localparam logic [1:0] FUNC_RED  = 2'd1;
    localparam logic [1:0] FUNC_PRIM = 2'd2;

    // Configuration register indexes and address width
    localparam int unsigned ADDR_W     = 3;
    localparam logic        REG_PT_IDX  = 1'b0;
    localparam logic        REG_MAX_IDX = 1'b1;

    // Register reset values
    localparam logic [7:0]  PT_RESET  = 8'd111;
    localparam logic [15:0] MAX_RESET = 16'd1200;

    // RED header constants
    localparam logic [7:0]  HDR_MARK      = 8'h80;
    localparam logic [17:0] RED_HDR_BYTES = 18'd5;
    localparam int unsigned TS_OFF_W      = 14;
    localparam int unsigned RED_LEN_W     = 10;

    // Header emission steps: four block header bytes, then the primary header
    localparam logic [2:0] STEP_MARK   = 3'd0;
    localparam logic [2:0] STEP_TS_HI  = 3'd1;
    localparam logic [2:0] STEP_TS_LO  = 3'd2;
    localparam logic [2:0] STEP_LEN_LO = 3'd3;
    localparam logic [2:0] STEP_LAST   = 3'd4;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_HDR,
        JOB_REJECT
    } job_kind_t;

    // One request from the front part to the back part
    typedef struct packed {
        job_kind_t              kind;
        logic [7:0]             data;
        logic                   last;
        logic                   used;
        logic [TS_OFF_W-1:0]    ts_off;
        logic [RED_LEN_W-1:0]   red_len;
    } job_t;

endpackage

>>> hw/rtl/rapf_if.sv
// ----------------------------------------------------------------------------
// rapf_in_if / rapf_out_if
// Valid/ready channels for input items and framed result bytes.
// ----------------------------------------------------------------------------
interface rapf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [15:0] primary_size;
    logic [15:0] redundant_size;
    logic        redundant_present;
    logic [31:0] primary_timestamp;
    logic [31:0] redundant_timestamp;

    modport source (
        output valid, func, data_byte, primary_size, redundant_size,
               redundant_present, primary_timestamp, redundant_timestamp,
        input  ready
    );
    modport sink (
        input  valid, func, data_byte, primary_size, redundant_size,
               redundant_present, primary_timestamp, redundant_timestamp,
        output ready
    );
endinterface

interface rapf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       redundancy_used;
    logic       status;

    modport source (
        output valid, out_byte, packet_end, redundancy_used, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, packet_end, redundancy_used, status,
        output ready
    );
endinterface

>>> hw/rtl/rapf_front.sv
// ----------------------------------------------------------------------------
// rapf_front
// Accepts input items, checks descriptors, tracks byte counters and
// queues one request per result-producing item.
// ----------------------------------------------------------------------------
module rapf_front
    import rapf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rapf_in_if.sink     in_ch,
    input  logic [7:0]  pt,
    input  logic [15:0] size_limit,
    input  logic        queue_full,
    output logic        push,
    output job_t        push_job
);

    logic        red_ok_reg,    red_ok_next;
    logic [15:0] red_left_reg,  red_left_next;
    logic [15:0] prim_left_reg, prim_left_next;

    logic        accept;
    logic        reject;
    logic [31:0] ts_off;
    logic        ts_ok;
    logic        len_ok;
    logic [17:0] total;
    logic        size_ok;
    logic        ok;
    logic [15:0] red_dec;
    logic [15:0] prim_dec;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Descriptor checks
    assign reject  = pt[7] || (size_limit == 16'd0);
    assign ts_off  = in_ch.primary_timestamp - in_ch.redundant_timestamp;
    assign ts_ok   = (ts_off != 32'd0) && (ts_off[31:TS_OFF_W] == '0);
    assign len_ok  = (in_ch.redundant_size != 16'd0)
                  && (in_ch.redundant_size[15:RED_LEN_W] == '0);
    assign total   = {2'b00, in_ch.primary_size} + {2'b00, in_ch.redundant_size}
                   + RED_HDR_BYTES;
    assign size_ok = total <= {2'b00, size_limit};
    assign ok      = in_ch.redundant_present && len_ok && ts_ok && size_ok;

    assign red_dec  = red_left_reg - 16'd1;
    assign prim_dec = prim_left_reg - 16'd1;

    // Update counters and build the request
    always_comb
    begin
        red_ok_next    = red_ok_reg;
        red_left_next  = red_left_reg;
        prim_left_next = prim_left_reg;
        push           = 1'b0;
        push_job       = '0;
        push_job.kind  = JOB_BYTE;
        push_job.data  = in_ch.data_byte;
        push_job.used  = red_ok_reg;
        if (accept)
        begin
            case (in_ch.func)
                FUNC_DESC:
                begin
                    push             = 1'b1;
                    push_job.ts_off  = ts_off[TS_OFF_W-1:0];
                    push_job.red_len = in_ch.redundant_size[RED_LEN_W-1:0];
                    push_job.data    = pt;
                    if (reject)
                    begin
                        push_job.kind  = JOB_REJECT;
                        push_job.last  = 1'b1;
                        push_job.used  = 1'b0;
                        red_ok_next    = 1'b0;
                        red_left_next  = 16'd0;
                        prim_left_next = 16'd0;
                    end
                    else
                    begin
                        push_job.kind  = JOB_HDR;
                        push_job.used  = ok;
                        push_job.last  = !ok && (in_ch.primary_size == 16'd0);
                        red_ok_next    = ok;
                        red_left_next  = ok ? in_ch.redundant_size : 16'd0;
                        prim_left_next = in_ch.primary_size;
                    end
                end
                FUNC_RED:
                begin
                    if (red_left_reg != 16'd0)
                    begin
                        push          = 1'b1;
                        push_job.last = (red_dec == 16'd0) && (prim_left_reg == 16'd0);
                        red_left_next = red_dec;
                    end
                end
                FUNC_PRIM:
                begin
                    if ((prim_left_reg != 16'd0) && (red_left_reg == 16'd0))
                    begin
                        push           = 1'b1;
                        push_job.last  = (prim_dec == 16'd0);
                        prim_left_next = prim_dec;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Hold packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ok_reg    <= 1'b0;
            red_left_reg  <= 16'd0;
            prim_left_reg <= 16'd0;
        end
        else
        begin
            red_ok_reg    <= red_ok_next;
            red_left_reg  <= red_left_next;
            prim_left_reg <= prim_left_next;
        end
    end

endmodule

>>> hw/rtl/rapf_queue.sv
// ----------------------------------------------------------------------------
// rapf_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module rapf_queue
    import rapf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t rd_job,
    output logic empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> hw/rtl/rapf_back.sv
// ----------------------------------------------------------------------------
// rapf_back
// Expands queued requests into framed bytes, one per cycle while the output is not
// stalled, through an output register.
// ----------------------------------------------------------------------------
module rapf_back
    import rapf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  job_t        head,
    output logic        pop,
    rapf_out_if.source  out_ch
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       used_reg, used_next;
    logic       status_reg, status_next;
    logic       load;
    logic       last_step;

    assign load = !queue_empty && (!valid_reg || out_ch.ready);

    // Last step of the head request
    assign last_step = (head.kind != JOB_HDR) || !head.used || (step_reg == STEP_LAST);
    assign pop       = load && last_step;

    // Select the next byte
    always_comb
    begin
        byte_next   = head.data;
        end_next    = 1'b0;
        used_next   = head.used;
        status_next = 1'b0;
        case (head.kind)
            JOB_REJECT:
            begin
                byte_next   = 8'd0;
                end_next    = 1'b1;
                used_next   = 1'b0;
                status_next = 1'b1;
            end
            JOB_HDR:
            begin
                if (!head.used)
                begin
                    end_next = head.last;
                end
                else
                begin
                    case (step_reg)
                        STEP_MARK:   byte_next = HDR_MARK | head.data;
                        STEP_TS_HI:  byte_next = head.ts_off[TS_OFF_W-1:6];
                        STEP_TS_LO:  byte_next = {head.ts_off[5:0], head.red_len[9:8]};
                        STEP_LEN_LO: byte_next = head.red_len[7:0];
                        default:     byte_next = head.data;
                    endcase
                end
            end
            default:
            begin
                end_next = head.last;
            end
        endcase
    end

    // Advance step and output valid
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = last_step ? STEP_MARK : step_reg + 3'd1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_MARK;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            end_reg    <= end_next;
            used_reg   <= used_next;
            status_reg <= status_next;
        end
    end

    assign out_ch.valid           = valid_reg;
    assign out_ch.out_byte        = byte_reg;
    assign out_ch.packet_end      = end_reg;
    assign out_ch.redundancy_used = used_reg;
    assign out_ch.status          = status_reg;

endmodule

>>> hw/rtl/red_audio_packet_framer.sv
// ----------------------------------------------------------------------------
// red_audio_packet_framer
// RFC 2198 redundant-audio packet framer: frames headers and payload bytes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        func, data_byte, sizes, timestamps
//  out_ch    source     valid/ready        out_byte, packet_end, used, status
//  apb       slave      psel/penable       2 registers at byte 0 and 4
//
//  Payload bytes pass through the request queue and the output register,
//  one per cycle while out_ch is not stalled. A descriptor with the
//  redundant block gives five header bytes; other descriptors and rejects one.
//  The request queue holds QUEUE_DEPTH entries; in_ch.ready drops when full.
//  Reset clears counters and queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module red_audio_packet_framer
    import rapf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    rapf_in_if.sink           in_ch,
    rapf_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0]  pt_reg,  pt_next;
    logic [15:0] max_reg, max_next;
    logic        cfg_wr;
    logic        reg_idx;
    logic        push;
    job_t        push_job;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;
    job_t        head;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb
    begin
        pt_next  = pt_reg;
        max_next = max_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_PT_IDX:  pt_next  = pwdata[7:0];
                REG_MAX_IDX: max_next = pwdata[15:0];
                default:     pt_next  = pt_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PT_IDX:  prdata = {24'd0, pt_reg};
            REG_MAX_IDX: prdata = {16'd0, max_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg  <= PT_RESET;
            max_reg <= MAX_RESET;
        end
        else
        begin
            pt_reg  <= pt_next;
            max_reg <= max_next;
        end
    end

    rapf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pt         (pt_reg),
        .size_limit (max_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    rapf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .full   (queue_full),
        .pop    (pop),
        .rd_job (head),
        .empty  (queue_empty)
    );

    rapf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

>>> hw/rtl/rapf_checker.sv
// ----------------------------------------------------------------------------
// rapf_checker
// Port-level checks on the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rapf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       packet_end,
    input logic       redundancy_used,
    input logic       status,
    input logic       pready
);

    // A reject result carries no byte and closes the packet
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> packet_end && !redundancy_used && (out_byte == 8'd0))
        else $error("reject result with bad fields");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(packet_end) && $stable(redundancy_used) && $stable(status))
        else $error("stalled result changed");

    // No result right out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

    // Register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind red_audio_packet_framer rapf_checker u_rapf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .packet_end      (out_ch.packet_end),
    .redundancy_used (out_ch.redundancy_used),
    .status          (out_ch.status),
    .pready          (pready)
);
